>>> sv/arqf_pkg.sv
// Shared types and constants for the ARP request filter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package arqf_pkg;

  localparam int MAX_ENTRIES    = 3;   // entries taken into the MAC compare
  localparam int NUM_ENTRY_REGS = 3;   // entries held in configuration
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int CFG_W  = 48;
  localparam int CNT_W  = 2;

  // Byte offsets within the frame
  localparam logic [5:0] POS_ETH_LO = 6'd12;
  localparam logic [5:0] POS_ETH_HI = 6'd14;
  localparam logic [5:0] POS_OP_LO  = 6'd20;
  localparam logic [5:0] POS_OP_HI  = 6'd22;
  localparam logic [5:0] POS_SIP_LO = 6'd28;
  localparam logic [5:0] POS_MAC_LO = 6'd32;
  localparam logic [5:0] POS_TIP_LO = 6'd38;
  localparam logic [5:0] ARP_LEN    = 6'd42;

  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

  typedef enum logic [2:0] {
    REG_OWN_IP      = 3'd0,
    REG_ENTRY_COUNT = 3'd1,
    REG_ENTRY0_MAC  = 3'd2,
    REG_ENTRY0_MASK = 3'd3,
    REG_ENTRY1_MAC  = 3'd4,
    REG_ENTRY1_MASK = 3'd5,
    REG_ENTRY2_MAC  = 3'd6,
    REG_ENTRY2_MASK = 3'd7
  } arqf_reg_t;

  // One classified frame, handed from front to back
  typedef struct packed {
    logic              arp;
    logic              is_request;
    logic [MAC_W-1:0]  target_mac;
    logic [IP_W-1:0]   sender_ip;   // zero when not ARP
    logic [IP_W-1:0]   target_ip;   // zero when not ARP
  } arqf_rec_t;

endpackage

>>> sv/arqf_front.sv
// Front end: takes frame bytes, captures header fields, classifies on last byte.
// Depends on arqf_pkg.
module arqf_front
  import arqf_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      frame_byte,
  input  logic            frame_end,
  output logic            push,
  output arqf_rec_t       push_rec,
  input  logic            push_ready
);

  logic [5:0]       byte_position, byte_position_next;
  logic [15:0]      seen_ethertype, seen_ethertype_next;
  logic [15:0]      seen_opcode, seen_opcode_next;
  logic [MAC_W-1:0] seen_target_mac, seen_target_mac_next;
  logic [IP_W-1:0]  seen_sender_ip, seen_sender_ip_next;
  logic [IP_W-1:0]  seen_target_ip, seen_target_ip_next;
  logic             accept;
  logic             arp;

  // only the last byte of a frame needs queue space
  assign in_ready = push_ready | ~frame_end;
  assign accept   = in_valid & in_ready;

  always_comb begin
    byte_position_next   = byte_position;
    seen_ethertype_next  = seen_ethertype;
    seen_opcode_next     = seen_opcode;
    seen_target_mac_next = seen_target_mac;
    seen_sender_ip_next  = seen_sender_ip;
    seen_target_ip_next  = seen_target_ip;
    if (byte_position < ARP_LEN) begin
      byte_position_next = byte_position + 6'd1;
      priority if (byte_position >= POS_ETH_LO && byte_position < POS_ETH_HI) begin
        seen_ethertype_next = {seen_ethertype[7:0], frame_byte};
      end else if (byte_position >= POS_OP_LO && byte_position < POS_OP_HI) begin
        seen_opcode_next = {seen_opcode[7:0], frame_byte};
      end else if (byte_position >= POS_SIP_LO && byte_position < POS_MAC_LO) begin
        seen_sender_ip_next = {seen_sender_ip[IP_W-9:0], frame_byte};
      end else if (byte_position >= POS_MAC_LO && byte_position < POS_TIP_LO) begin
        seen_target_mac_next = {seen_target_mac[MAC_W-9:0], frame_byte};
      end else if (byte_position >= POS_TIP_LO) begin
        seen_target_ip_next = {seen_target_ip[IP_W-9:0], frame_byte};
      end else begin
        seen_ethertype_next = seen_ethertype;
      end
    end
  end

  assign arp = (byte_position_next >= ARP_LEN) && (seen_ethertype_next == ETHERTYPE_ARP);

  assign push                = accept & frame_end;
  assign push_rec.arp        = arp;
  assign push_rec.is_request = (seen_opcode_next == ARP_OP_REQUEST);
  assign push_rec.target_mac = seen_target_mac_next;
  assign push_rec.sender_ip  = arp ? seen_sender_ip_next : '0;
  assign push_rec.target_ip  = arp ? seen_target_ip_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= frame_end ? '0 : byte_position_next;
    end
  end

  // fields are fully rewritten by any frame long enough to use them
  always_ff @(posedge clk) begin
    if (accept) begin
      seen_ethertype  <= seen_ethertype_next;
      seen_opcode     <= seen_opcode_next;
      seen_target_mac <= seen_target_mac_next;
      seen_sender_ip  <= seen_sender_ip_next;
      seen_target_ip  <= seen_target_ip_next;
    end
  end

endmodule

>>> sv/arqf_queue.sv
// Small FIFO of classified frames between front and back.
// Depends on arqf_pkg.
module arqf_queue
  import arqf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  arqf_rec_t push_rec,
  output logic      push_ready,
  input  logic      pop,
  output arqf_rec_t pop_rec,
  output logic      pop_valid
);

  arqf_rec_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0]   fill;
  logic                  do_push, do_pop;

  assign push_ready = (fill != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_rec    = slots[rd_ptr];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

>>> sv/arqf_back.sv
// Back end: configuration registers, IP and masked MAC match, output register.
// Depends on arqf_pkg.
module arqf_back
  import arqf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             pop_valid,
  input  arqf_rec_t        pop_rec,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             request_accepted,
  output logic             arp_frame_seen,
  output logic [IP_W-1:0]  peer_ip,
  output logic [IP_W-1:0]  asked_ip
);

  logic [IP_W-1:0]  own_ip_address;
  logic [CNT_W-1:0] entry_count;
  logic [MAC_W-1:0] entry_mac  [NUM_ENTRY_REGS];
  logic [MAC_W-1:0] entry_mask [NUM_ENTRY_REGS];
  logic [CNT_W-1:0] eff_count;
  logic             mac_hit;
  logic             accepted;
  arqf_reg_t        reg_sel;

  assign reg_sel = arqf_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip_address <= '0;
      entry_count    <= '0;
      for (int k = 0; k < NUM_ENTRY_REGS; k++) begin
        entry_mac[k]  <= '0;
        entry_mask[k] <= '0;
      end
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_OWN_IP:      own_ip_address <= cfg_data[IP_W-1:0];
        REG_ENTRY_COUNT: entry_count    <= cfg_data[CNT_W-1:0];
        REG_ENTRY0_MAC:  entry_mac[0]   <= cfg_data[MAC_W-1:0];
        REG_ENTRY0_MASK: entry_mask[0]  <= cfg_data[MAC_W-1:0];
        REG_ENTRY1_MAC:  entry_mac[1]   <= cfg_data[MAC_W-1:0];
        REG_ENTRY1_MASK: entry_mask[1]  <= cfg_data[MAC_W-1:0];
        REG_ENTRY2_MAC:  entry_mac[2]   <= cfg_data[MAC_W-1:0];
        REG_ENTRY2_MASK: entry_mask[2]  <= cfg_data[MAC_W-1:0];
        default:         own_ip_address <= own_ip_address;
      endcase
    end
  end

  assign eff_count = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;

  always_comb begin
    mac_hit = (eff_count == '0);
    for (int k = 0; k < NUM_ENTRY_REGS; k++) begin
      if ((CNT_W'(k) < eff_count) &&
          ((pop_rec.target_mac & entry_mask[k]) == (entry_mac[k] & entry_mask[k]))) begin
        mac_hit = 1'b1;
      end
    end
  end

  assign accepted = pop_rec.arp & pop_rec.is_request &
                    (pop_rec.target_ip == own_ip_address) & mac_hit;

  assign pop = pop_valid & (~out_valid | out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      request_accepted <= accepted;
      arp_frame_seen   <= pop_rec.arp;
      peer_ip          <= pop_rec.sender_ip;
      asked_ip         <= pop_rec.target_ip;
    end
  end

endmodule

>>> sv/arp_request_mac_filter_core.sv
// Top level of the ARP request filter: front end, frame queue and back end.
// Depends on arqf_pkg, arqf_front, arqf_queue and arqf_back.
//
// Takes one frame byte per clock with no gaps of its own; the input stalls only
// when a frame's last byte arrives while the two-entry frame queue is full,
// which happens only when three results are already waiting: one in the output
// register and two in the queue. A frame's record is written into the queue at
// the edge that takes its last byte, and its result is loaded into the output
// register once it reaches the queue head and the output register is free or
// being taken. The IP compare and the three masked 48-bit MAC compares run
// from the queue head into the output register. Results are held until taken,
// while the front keeps capturing the next frame. Configuration writes take
// effect on the next clock and should only be made between frames with no
// result pending.
module arp_request_mac_filter_core
  import arqf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       frame_byte,
  input  logic             frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             request_accepted,
  output logic             arp_frame_seen,
  output logic [IP_W-1:0]  peer_ip,
  output logic [IP_W-1:0]  asked_ip
);

  logic      push, push_ready, pop, pop_valid;
  arqf_rec_t push_rec, pop_rec;

  arqf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .push       (push),
    .push_rec   (push_rec),
    .push_ready (push_ready)
  );

  arqf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_rec    (pop_rec),
    .pop_valid  (pop_valid)
  );

  arqf_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pop_valid        (pop_valid),
    .pop_rec          (pop_rec),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .request_accepted (request_accepted),
    .arp_frame_seen   (arp_frame_seen),
    .peer_ip          (peer_ip),
    .asked_ip         (asked_ip)
  );

endmodule

>>> sv/arqf_checker.sv
// Port-level checks for the ARP request filter, bound to the top level.
// Depends on arqf_pkg and arp_request_mac_filter_core.
module arqf_checker
  import arqf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             frame_end,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             request_accepted,
  input  logic             arp_frame_seen,
  input  logic [IP_W-1:0]  peer_ip,
  input  logic [IP_W-1:0]  asked_ip
);

  // a pending result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(request_accepted) &&
    $stable(arp_frame_seen) && $stable(peer_ip) && $stable(asked_ip))
    else $error("result changed while stalled");

  a_acc_arp: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_accepted |-> arp_frame_seen)
    else $error("accepted frame not flagged as ARP");

  a_non_arp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !arp_frame_seen |-> peer_ip == '0 && asked_ip == '0)
    else $error("addresses reported for a non-ARP frame");

  // only the last byte of a frame can be held off
  a_mid_frame_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !frame_end |-> in_ready)
    else $error("mid-frame byte stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind arp_request_mac_filter_core arqf_checker u_arqf_checker (.*);
